>>> src/piecewise_poly_morph_shaper_defines.svh
// ============================================================================
// Piecewise polynomial morph shaper assertion macros
// Shared property templates for the port-level checker.
// ============================================================================
`ifndef PIECEWISE_POLY_MORPH_SHAPER_DEFINES_SVH
`define PIECEWISE_POLY_MORPH_SHAPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPMS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPMS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ppms_pkg.sv
// ============================================================================
// Piecewise polynomial morph shaper package
// Item kinds and fixed-point constants shared by the shaper and its checker.
// ============================================================================
`default_nettype none

package ppms_pkg;

    // Kind of an input item, carried on the slave tuser.
    typedef enum logic [1:0] {
        MODE_BP_WRITE   = 2'd0,
        MODE_COEF_WRITE = 2'd1,
        MODE_SHAPE      = 2'd2,
        MODE_NONE       = 2'd3
    } mode_t;

    // Field widths fixed by the item format.
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 6;
    localparam int WEIGHT_W = 17;
    localparam int PIECE_W  = 4;

    // Full morph weight (1.0 in Q1.16) and 1.0 in Q2.14.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
    localparam logic signed [16:0]  IDENTITY_ONE = 17'sd16384;

    // Saturation bounds of a Q1.15 result.
    localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [15:0] SAT_MIN = 16'sh8000;

endpackage

`default_nettype wire

>>> src/piecewise_poly_morph_shaper.sv
// ============================================================================
// Piecewise polynomial morph shaper
// Picks a piece by breakpoint scan, blends its coefficients toward the target
// by the morph weight and evaluates the polynomial by Horner's rule.
// ============================================================================
// A sample scans the breakpoint memory one entry per cycle, then the Horner loop
// blends and accumulates the coefficients from the top power down, and the
// result register is loaded once it is free of a stalled result. No new item,
// table writes included, is taken until the result is loaded. Reset clears control
// state and the morph weight; the table memories must be written before use.
`default_nettype none

module piecewise_poly_morph_shaper #(
    parameter int PIECES = 10,
    parameter int DEGREE = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // Morph weight register write.
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // table_index[5:0], table_value[21:6],
                                        // sample[37:22], zeros[39:38]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // shaped_sample[15:0], piece_used[19:16],
                                        // zeros[23:20]
    output logic [0:0]  m_axis_tuser    // clipped[0]
);

    // Table geometry and datapath widths.
    localparam int BP_CNT   = PIECES - 1;
    localparam int COEF_CNT = PIECES * (DEGREE + 1);
    localparam int BA_W     = (BP_CNT > 1) ? $clog2(BP_CNT) : 1;
    localparam int CA_W     = $clog2(COEF_CNT);
    localparam int PC_W     = $clog2(PIECES);
    localparam int PW_W     = $clog2(DEGREE + 2);
    localparam int ACC_W    = 34 + $clog2(DEGREE + 1);
    localparam int MUL_W    = ACC_W + ppms_pkg::SAMPLE_W;

    localparam logic signed [MUL_W-1:0] RND_MUL = MUL_W'(1) <<< 14;
    localparam logic signed [ACC_W-1:0] RND_ACC = ACC_W'(1) <<< 14;
    localparam logic signed [34:0]      RND_BL  = 35'sd32768;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_POLY = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Input field unpacking.
    ppms_pkg::mode_t             in_mode;
    logic [ppms_pkg::INDEX_W-1:0] in_index;
    logic signed [15:0]          in_value;
    logic signed [15:0]          in_sample;

    assign in_mode   = ppms_pkg::mode_t'(s_axis_tuser);
    assign in_index  = s_axis_tdata[5:0];
    assign in_value  = s_axis_tdata[21:6];
    assign in_sample = s_axis_tdata[37:22];

    state_t state_reg, state_next;

    logic [ppms_pkg::WEIGHT_W-1:0] weight_reg;
    logic signed [15:0]            x_reg;

    // Breakpoint scan state.
    logic [15:0]     bp_mem [BP_CNT];
    logic signed [15:0] bp_q_reg;
    logic [BA_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CA_W-1:0] base_reg, base_next;
    logic [PC_W-1:0] piece_reg, piece_next;

    // Coefficient fetch and blend pipeline.
    logic [15:0]     cf_mem [COEF_CNT];
    logic signed [15:0] ct_q_reg;
    logic [CA_W-1:0] rd_addr_reg, rd_addr_next;
    logic [PW_W-1:0] iss_left_reg, iss_left_next;
    logic            iss_phase_reg, iss_phase_next;
    logic            ct_vld_reg, ct_one_reg;
    logic signed [34:0] prod_reg;
    logic            pr_vld_reg, pr_one_reg;
    logic signed [15:0] coef_reg;
    logic            cf_vld_reg;

    // Horner loop state.
    logic [PW_W-1:0]        cf_left_reg, cf_left_next;
    logic                   acc_first_reg, acc_first_next;
    logic                   mul_go_reg, mul_go_next;
    logic signed [MUL_W-1:0] mul_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_sample_reg;
    logic [PC_W-1:0]    out_piece_reg;
    logic               out_clip_reg;

    // Handshake and control decode.
    logic in_fire, sample_fire, out_fire, out_load;
    logic bp_we, cf_we, bp_re, cf_re;
    logic bp_hit, bp_last;
    logic [BA_W-1:0] bp_raddr;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sample_fire   = in_fire && (in_mode == ppms_pkg::MODE_SHAPE);
    assign bp_we         = in_fire && (in_mode == ppms_pkg::MODE_BP_WRITE)
                           && (32'(in_index) < 32'(BP_CNT));
    assign cf_we         = in_fire && (in_mode == ppms_pkg::MODE_COEF_WRITE)
                           && (32'(in_index) < 32'(COEF_CNT));
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // First-match test of the breakpoint held in the read register.
    assign bp_hit  = x_reg < bp_q_reg;
    assign bp_last = (cmp_idx_reg == BA_W'(BP_CNT - 1));
    assign bp_re   = sample_fire || ((state_reg == S_SCAN) && !bp_hit && !bp_last);
    assign bp_raddr = sample_fire ? '0 : cmp_idx_reg + BA_W'(1);

    // Coefficients are fetched from the top power down, only while the issue phase bit is clear.
    assign cf_re = (state_reg == S_POLY) && (iss_left_reg != '0) && !iss_phase_reg;

    // Blend datapath: c = id + rnd((t - id) * w / 2^16).
    logic signed [16:0] blend_diff;
    logic signed [17:0] weight_s;
    logic signed [34:0] blend_prod;
    logic signed [34:0] blend_rnd;
    logic signed [16:0] blend_coef;

    assign blend_diff = {ct_q_reg[15], ct_q_reg}
                        - (ct_one_reg ? ppms_pkg::IDENTITY_ONE : 17'sd0);
    assign weight_s   = $signed({1'b0, weight_reg});
    assign blend_prod = blend_diff * weight_s;
    assign blend_rnd  = (prod_reg + RND_BL) >>> 16;
    assign blend_coef = blend_rnd[16:0]
                        + (pr_one_reg ? ppms_pkg::IDENTITY_ONE : 17'sd0);

    // Horner step: acc = rnd(acc * x / 2^15) + c * 2^16, folded into one sum.
    logic signed [MUL_W-1:0] coef_wide;
    logic signed [MUL_W-1:0] horner_sum;
    logic signed [MUL_W-1:0] horner_shr;
    logic signed [ACC_W-1:0] acc_init;
    logic signed [MUL_W-1:0] mul_next;

    assign coef_wide  = MUL_W'(coef_reg);
    assign horner_sum = mul_reg + (coef_wide <<< 31) + RND_MUL;
    assign horner_shr = horner_sum >>> 15;
    assign acc_init   = ACC_W'(coef_reg) <<< 16;
    assign mul_next   = acc_reg * x_reg;

    // Final rounding and saturation to Q1.15.
    logic signed [ACC_W-1:0] y_wide;
    logic                    y_hi, y_lo;

    assign y_wide = (acc_reg + RND_ACC) >>> 15;
    assign y_hi   = y_wide > ACC_W'(ppms_pkg::SAT_MAX);
    assign y_lo   = y_wide < ACC_W'(ppms_pkg::SAT_MIN);

    // Sequencer and loop counters.
    always_comb
    begin
        state_next     = state_reg;
        cmp_idx_next   = cmp_idx_reg;
        base_next      = base_reg;
        piece_next     = piece_reg;
        rd_addr_next   = rd_addr_reg;
        iss_left_next  = iss_left_reg;
        iss_phase_next = iss_phase_reg;
        cf_left_next   = cf_left_reg;
        acc_first_next = acc_first_reg;
        mul_go_next    = cf_vld_reg && (cf_left_reg != PW_W'(1));
        out_valid_next = out_valid_reg;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_fire)
                begin
                    cmp_idx_next = '0;
                    base_next    = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (bp_hit || bp_last)
                begin
                    piece_next     = bp_hit ? PC_W'(cmp_idx_reg) : PC_W'(PIECES - 1);
                    rd_addr_next   = bp_hit ? base_reg + CA_W'(DEGREE)
                                            : CA_W'(COEF_CNT - 1);
                    iss_left_next  = PW_W'(DEGREE + 1);
                    iss_phase_next = 1'b0;
                    cf_left_next   = PW_W'(DEGREE + 1);
                    acc_first_next = 1'b1;
                    state_next     = S_POLY;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + BA_W'(1);
                    base_next    = base_reg + CA_W'(DEGREE + 1);
                end
            end
            S_POLY:
            begin
                iss_phase_next = !iss_phase_reg;
                if (cf_re)
                begin
                    rd_addr_next  = rd_addr_reg - CA_W'(1);
                    iss_left_next = iss_left_reg - PW_W'(1);
                end
                if (cf_vld_reg)
                begin
                    cf_left_next   = cf_left_reg - PW_W'(1);
                    acc_first_next = 1'b0;
                    if (cf_left_reg == PW_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            weight_reg    <= '0;
            cmp_idx_reg   <= '0;
            base_reg      <= '0;
            piece_reg     <= '0;
            rd_addr_reg   <= '0;
            iss_left_reg  <= '0;
            iss_phase_reg <= 1'b0;
            ct_vld_reg    <= 1'b0;
            pr_vld_reg    <= 1'b0;
            cf_vld_reg    <= 1'b0;
            cf_left_reg   <= '0;
            acc_first_reg <= 1'b0;
            mul_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_idx_reg   <= cmp_idx_next;
            base_reg      <= base_next;
            piece_reg     <= piece_next;
            rd_addr_reg   <= rd_addr_next;
            iss_left_reg  <= iss_left_next;
            iss_phase_reg <= iss_phase_next;
            ct_vld_reg    <= cf_re;
            pr_vld_reg    <= ct_vld_reg;
            cf_vld_reg    <= pr_vld_reg;
            cf_left_reg   <= cf_left_next;
            acc_first_reg <= acc_first_next;
            mul_go_reg    <= mul_go_next;
            out_valid_reg <= out_valid_next;
            // The stored weight is already saturated to 1.0.
            if (cfg_wr_en)
            begin
                weight_reg <= (cfg_wr_data > ppms_pkg::WEIGHT_ONE)
                              ? ppms_pkg::WEIGHT_ONE : cfg_wr_data;
            end
        end
    end

    // Breakpoint memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[BA_W'(in_index)] <= in_value;
        end
        if (bp_re)
        begin
            bp_q_reg <= bp_mem[bp_raddr];
        end
    end

    // Coefficient memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cf_we)
        begin
            cf_mem[CA_W'(in_index)] <= in_value;
        end
        if (cf_re)
        begin
            ct_q_reg   <= cf_mem[rd_addr_reg];
            ct_one_reg <= (iss_left_reg == PW_W'(2));
        end
    end

    // Sample capture, blend and Horner datapath registers.
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            x_reg <= in_sample;
        end
        if (ct_vld_reg)
        begin
            prod_reg   <= blend_prod;
            pr_one_reg <= ct_one_reg;
        end
        if (pr_vld_reg)
        begin
            coef_reg <= blend_coef[15:0];
        end
        if (cf_vld_reg)
        begin
            acc_reg <= acc_first_reg ? acc_init : horner_shr[ACC_W-1:0];
        end
        if (mul_go_reg)
        begin
            mul_reg <= mul_next;
        end
        if (out_load)
        begin
            out_sample_reg <= y_hi ? ppms_pkg::SAT_MAX
                            : (y_lo ? ppms_pkg::SAT_MIN : y_wide[15:0]);
            out_clip_reg   <= y_hi || y_lo;
            out_piece_reg  <= piece_reg;
        end
    end

    // Result port.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, ppms_pkg::PIECE_W'(out_piece_reg), out_sample_reg};
    assign m_axis_tuser  = out_clip_reg;

endmodule

`default_nettype wire

>>> src/ppms_checker.sv
// ============================================================================
// Piecewise polynomial morph shaper port checker
// Watches the shaper's ports for handshake and result consistency.
// ============================================================================
`default_nettype none

`include "piecewise_poly_morph_shaper_defines.svh"

module ppms_checker #(
    parameter int PIECES = 10
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    logic sample_xfer;
    logic piece_ok;

    assign sample_xfer = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser == ppms_pkg::MODE_SHAPE);
    assign piece_ok    = (PIECES > 16) || (32'(m_axis_tdata[19:16]) < PIECES);

    // A stalled result transfer keeps its payload.
    `PPMS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // The clipped flag only comes with a full-scale sample.
    `PPMS_ASSERT_NOW(a_clip_rail, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[15:0] == 16'h7fff) || (m_axis_tdata[15:0] == 16'h8000), "clipped without saturated value")

    // The reported piece lies inside the table.
    `PPMS_ASSERT_NOW(a_piece_range, clk, rst_n, m_axis_tvalid, piece_ok, "piece out of range")

    // A sample transfer starts work that blocks the next input item.
    `PPMS_ASSERT_NEXT(a_busy_after_sample, clk, rst_n, sample_xfer, !s_axis_tready, "input taken while a sample is in work")

    // A new result appears only at the end of work on a sample.
    `PPMS_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared while idle")

endmodule

bind piecewise_poly_morph_shaper ppms_checker #(
    .PIECES (PIECES)
) u_ppms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
